/* sv/sccb_master_bit_engine_defines.svh */
// assertion macros used by the file that checks this block
`ifndef SCCB_MASTER_BIT_ENGINE_DEFINES_SVH
`define SCCB_MASTER_BIT_ENGINE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SCCB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sccb engine check failed");

// next-cycle implication, checked out of reset
`define SCCB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sccb engine check failed");

`endif

/* sv/sccb_pkg.sv */
package sccb_pkg;

    // bus command codes, as carried on the kind field
    typedef enum logic [2:0] {
        CMD_IDLE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_NOACK = 3'd3,
        CMD_WBYTE = 3'd4,
        CMD_RBYTE = 3'd5,
        CMD_WWORD = 3'd6
    } t_cmd;

    localparam int KIND_W  = 3;
    localparam int DATA_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int TICK_W  = 16;
    localparam int PHASE_W = 3;
    localparam int BIT_W   = 3;

    localparam logic [TICK_W-1:0] PHASE_TICKS_RST = 16'd100;
    localparam logic [BIT_W-1:0]  LAST_BIT        = 3'd7;

    // line actions of the simple commands: bit 1 picks scl, bit 0 is the level
    localparam logic [1:0] START_SEQ [0:3] = '{2'd1, 2'd3, 2'd0, 2'd2};
    localparam logic [1:0] STOP_SEQ  [0:2] = '{2'd0, 2'd3, 2'd1};
    localparam logic [1:0] NOACK_SEQ [0:3] = '{2'd1, 2'd3, 2'd2, 2'd0};

    // classified beat as held in the queue
    typedef struct packed {
        logic              is_cmd;
        t_cmd              cmd;
        logic [DATA_W-1:0] shift_init;
        logic              sda_in;
    } t_item;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // one result beat
    typedef struct packed {
        logic              scl;
        logic              sda_out;
        logic              sda_drive;
        logic              busy;
        logic              done;
        logic              ack_ok;
        logic [BYTE_W-1:0] read_data;
        logic              rejected;
    } t_result;

endpackage

/* sv/sccb_front.sv */
module sccb_front (
    input  logic                          i_valid,
    input  logic [sccb_pkg::KIND_W-1:0]   i_kind,
    input  logic [sccb_pkg::DATA_W-1:0]   i_data,
    input  logic                          i_sda_in,
    input  sccb_pkg::t_q_stat             i_q_stat,
    output logic                          o_stall,
    output logic                          o_push,
    output sccb_pkg::t_item               o_item
);
    import sccb_pkg::*;

    // hold off upstream while the queue has no room
    assign o_stall = i_q_stat.full;
    assign o_push  = i_valid && !i_q_stat.full;

    // classify the kind and pre-load the shift word
    always_comb begin
        o_item.sda_in = i_sda_in;
        case (i_kind)
            CMD_START, CMD_STOP, CMD_NOACK, CMD_WBYTE, CMD_RBYTE, CMD_WWORD: begin
                o_item.is_cmd = 1'b1;
                o_item.cmd    = t_cmd'(i_kind);
            end
            default: begin
                o_item.is_cmd = 1'b0;
                o_item.cmd    = CMD_IDLE;
            end
        endcase
        case (o_item.cmd)
            CMD_WWORD: o_item.shift_init = i_data;
            CMD_WBYTE: o_item.shift_init = {i_data[BYTE_W-1:0], {BYTE_W{1'b0}}};
            default:   o_item.shift_init = '0;
        endcase
    end

endmodule

/* sv/sccb_queue.sv */
module sccb_queue #(
    parameter int DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sccb_pkg::t_item   i_wdata,
    input  logic              i_pop,
    output sccb_pkg::t_item   o_rdata,
    output sccb_pkg::t_q_stat o_stat
);
    import sccb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_item             r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              wr_en, rd_en;

    assign o_stat.full  = (r_count == CNT_FULL);
    assign o_stat.empty = (r_count == '0);
    assign wr_en        = i_push && !o_stat.full;
    assign rd_en        = i_pop && !o_stat.empty;
    assign o_rdata      = r_mem[r_rd_ptr];

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({wr_en, rd_en})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

/* sv/sccb_back.sv */
module sccb_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [sccb_pkg::TICK_W-1:0]  i_cfg_wdata,
    input  sccb_pkg::t_q_stat            i_q_stat,
    input  sccb_pkg::t_item              i_item,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_stall,
    output sccb_pkg::t_result            o_res
);
    import sccb_pkg::*;

    // engine state apart from the tick counter
    typedef struct packed {
        t_cmd               cmd;
        logic [PHASE_W-1:0] phase;
        logic [BIT_W-1:0]   bidx;
        logic [DATA_W-1:0]  shift;
        logic               scl;
        logic               sda;
        logic               sda_en;
        logic               second;
        logic               ack;
    } t_eng;

    t_eng              r_eng, n_eng;
    logic [TICK_W-1:0] r_tick, n_tick;
    logic [TICK_W-1:0] r_phase_ticks;
    t_result           r_res, n_res;
    logic              r_valid;

    t_eng              adv_raw, adv_ent, start_raw, start_ent;
    logic              finish, active, due;

    function automatic t_eng line_act(input t_eng e, input logic [1:0] act);
        t_eng r;
        r = e;
        if (act[1]) begin
            r.scl = act[0];
        end else begin
            r.sda = act[0];
        end
        return r;
    endfunction

    // line changes on entry to a phase
    function automatic t_eng enter_phase(input t_eng e, input logic sda_in);
        t_eng r;
        r = e;
        case (e.cmd)
            CMD_START: begin
                if (e.phase == 3'd0) begin
                    r.sda_en = 1'b1;
                end
                if (e.phase < 3'd4) begin
                    r = line_act(r, START_SEQ[e.phase[1:0]]);
                end
            end
            CMD_STOP: begin
                if (e.phase < 3'd3) begin
                    r = line_act(r, STOP_SEQ[e.phase[1:0]]);
                end
            end
            CMD_NOACK: begin
                if (e.phase < 3'd4) begin
                    r = line_act(r, NOACK_SEQ[e.phase[1:0]]);
                end
            end
            CMD_WBYTE, CMD_WWORD: begin
                case (e.phase)
                    3'd0: r.sda = e.shift[{1'b1, ~e.bidx}];
                    3'd1: r.scl = 1'b1;
                    3'd2: r.scl = 1'b0;
                    3'd4: r.sda_en = 1'b0;
                    3'd5: r.scl = 1'b1;
                    3'd6: begin
                        r.ack = !sda_in;
                        r.scl = 1'b0;
                    end
                    default: r = e;
                endcase
            end
            CMD_RBYTE: begin
                case (e.phase)
                    3'd0: r.sda_en = 1'b0;
                    3'd2: r.scl = 1'b1;
                    3'd3: begin
                        r.shift = {{BYTE_W{1'b0}}, e.shift[BYTE_W-2:0], sda_in};
                        r.scl   = 1'b0;
                    end
                    default: r = e;
                endcase
            end
            default: r = e;
        endcase
        return r;
    endfunction

    // take a beat whenever the queue holds one and the result register is free or being drained
    assign o_pop   = !i_q_stat.empty && (!r_valid || !i_stall);
    assign active  = (r_eng.cmd != CMD_IDLE);
    assign due     = (r_tick >= r_phase_ticks);
    assign o_valid = r_valid;
    assign o_res   = r_res;

    // phase advance of the running command
    always_comb begin
        adv_raw = r_eng;
        finish  = 1'b0;
        case (r_eng.cmd)
            CMD_START, CMD_NOACK: begin
                adv_raw.phase = r_eng.phase + 3'd1;
                finish        = (r_eng.phase >= 3'd3);
            end
            CMD_STOP: begin
                adv_raw.phase = r_eng.phase + 3'd1;
                finish        = (r_eng.phase >= 3'd2);
            end
            CMD_WBYTE, CMD_WWORD: begin
                if (r_eng.phase < 3'd2) begin
                    adv_raw.phase = r_eng.phase + 3'd1;
                end else if (r_eng.phase == 3'd2) begin
                    if (r_eng.bidx < LAST_BIT) begin
                        adv_raw.bidx  = r_eng.bidx + 3'd1;
                        adv_raw.phase = 3'd0;
                    end else begin
                        adv_raw.phase = 3'd3;
                    end
                end else if (r_eng.phase < 3'd6) begin
                    adv_raw.phase = r_eng.phase + 3'd1;
                end else begin
                    adv_raw.sda_en = 1'b1;
                    if (r_eng.cmd == CMD_WWORD && !r_eng.second && r_eng.ack) begin
                        adv_raw.second = 1'b1;
                        adv_raw.shift  = {r_eng.shift[BYTE_W-1:0], {BYTE_W{1'b0}}};
                        adv_raw.phase  = 3'd0;
                        adv_raw.bidx   = 3'd0;
                    end else begin
                        finish = 1'b1;
                    end
                end
            end
            CMD_RBYTE: begin
                if (r_eng.phase == 3'd0) begin
                    adv_raw.phase = 3'd1;
                    adv_raw.bidx  = 3'd0;
                end else if (r_eng.phase < 3'd3) begin
                    adv_raw.phase = r_eng.phase + 3'd1;
                end else if (r_eng.bidx < LAST_BIT) begin
                    adv_raw.bidx  = r_eng.bidx + 3'd1;
                    adv_raw.phase = 3'd1;
                end else begin
                    adv_raw.sda_en = 1'b1;
                    finish         = 1'b1;
                end
            end
            default: finish = 1'b1;
        endcase
        adv_ent = enter_phase(adv_raw, i_item.sda_in);
    end

    // first phase of a newly accepted command
    always_comb begin
        start_raw        = r_eng;
        start_raw.cmd    = i_item.cmd;
        start_raw.phase  = '0;
        start_raw.bidx   = '0;
        start_raw.second = 1'b0;
        start_raw.ack    = 1'b0;
        start_raw.shift  = i_item.shift_init;
        start_ent        = enter_phase(start_raw, i_item.sda_in);
    end

    // next state
    always_comb begin
        n_eng  = r_eng;
        n_tick = r_tick;
        if (o_pop) begin
            if (active) begin
                if (due) begin
                    if (finish) begin
                        n_eng       = adv_raw;
                        n_eng.cmd   = CMD_IDLE;
                        n_eng.phase = '0;
                        n_eng.bidx  = '0;
                        n_tick      = '0;
                    end else begin
                        n_eng  = adv_ent;
                        n_tick = TICK_W'(1);
                    end
                end else begin
                    n_tick = r_tick + 1'b1;
                end
            end else if (i_item.is_cmd) begin
                n_eng  = start_ent;
                n_tick = TICK_W'(1);
            end
        end
    end

    // result of this beat
    always_comb begin
        n_res.scl       = n_eng.scl;
        n_res.sda_out   = n_eng.sda;
        n_res.sda_drive = n_eng.sda_en;
        n_res.busy      = (n_eng.cmd != CMD_IDLE);
        n_res.rejected  = active && i_item.is_cmd;
        n_res.done      = active && due && finish;
        n_res.ack_ok    = n_res.done && r_eng.ack
                          && (r_eng.cmd == CMD_WBYTE || r_eng.cmd == CMD_WWORD);
        n_res.read_data = (n_res.done && r_eng.cmd == CMD_RBYTE)
                          ? r_eng.shift[BYTE_W-1:0] : '0;
    end

    // engine state and phase length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eng.cmd     <= CMD_IDLE;
            r_eng.phase   <= '0;
            r_eng.bidx    <= '0;
            r_eng.shift   <= '0;
            r_eng.scl     <= 1'b1;
            r_eng.sda     <= 1'b1;
            r_eng.sda_en  <= 1'b1;
            r_eng.second  <= 1'b0;
            r_eng.ack     <= 1'b0;
            r_tick        <= '0;
            r_phase_ticks <= PHASE_TICKS_RST;
        end else begin
            r_eng  <= n_eng;
            r_tick <= n_tick;
            if (i_cfg_we) begin
                r_phase_ticks <= i_cfg_wdata;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= n_res;
        end
    end

endmodule

/* sv/sccb_master_bit_engine.sv */
// channel   direction  handshake          payload
// input     in         i_valid / o_stall  i_kind, i_data, i_sda_in
// result    out        o_valid / i_stall  o_scl .. o_rejected
// config    in         i_cfg_we           i_cfg_wdata (phase ticks)
//
// one beat in and one result out per cycle, sustained while i_stall stays low; each
// beat is held in the queue, then its result in the engine's result register.
// the engine updates its whole state once for each beat that it pops.
// synchronous reset empties the queue, idles the engine and loads phase ticks 100.
// a stalled result holds in the output register; the queue keeps taking beats
// until it holds QUEUE_DEPTH, then o_stall rises.
`include "sccb_master_bit_engine_defines.svh"

module sccb_master_bit_engine #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [sccb_pkg::KIND_W-1:0]  i_kind,
    input  logic [sccb_pkg::DATA_W-1:0]  i_data,
    input  logic                         i_sda_in,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_scl,
    output logic                         o_sda_out,
    output logic                         o_sda_drive,
    output logic                         o_busy_res,
    output logic                         o_done_res,
    output logic                         o_ack_ok,
    output logic [sccb_pkg::BYTE_W-1:0]  o_read_data,
    output logic                         o_rejected,
    input  logic                         i_cfg_we,
    input  logic [sccb_pkg::TICK_W-1:0]  i_cfg_wdata
);
    import sccb_pkg::*;

    t_item   push_item, head_item;
    t_q_stat q_stat;
    t_result res;
    logic    push, pop;

    // classify incoming beats
    sccb_front u_front (
        .i_valid  (i_valid),
        .i_kind   (i_kind),
        .i_data   (i_data),
        .i_sda_in (i_sda_in),
        .i_q_stat (q_stat),
        .o_stall  (o_stall),
        .o_push   (push),
        .o_item   (push_item)
    );

    // decoupling queue
    sccb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (push_item),
        .i_pop   (pop),
        .o_rdata (head_item),
        .o_stat  (q_stat)
    );

    // bus engine and result register
    sccb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_stat    (q_stat),
        .i_item      (head_item),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_res       (res)
    );

    assign o_scl       = res.scl;
    assign o_sda_out   = res.sda_out;
    assign o_sda_drive = res.sda_drive;
    assign o_busy_res  = res.busy;
    assign o_done_res  = res.done;
    assign o_ack_ok    = res.ack_ok;
    assign o_read_data = res.read_data;
    assign o_rejected  = res.rejected;

    // checks
    `SCCB_ASSERT_NOW(a_done_not_busy, o_valid && o_done_res, !o_busy_res)
    `SCCB_ASSERT_NOW(a_status_only_with_done, o_valid && !o_done_res,
                     !o_ack_ok && (o_read_data == '0))
    `SCCB_ASSERT_NOW(a_queue_status, 1'b1, !(q_stat.full && q_stat.empty))
    `SCCB_ASSERT_NEXT(a_pop_gives_result, pop, o_valid)

endmodule

/* verif/sccb_master_bit_engine_checker.sv */
`timescale 1ns / 1ps

module sccb_master_bit_engine_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  logic [sccb_pkg::KIND_W-1:0]  i_kind,
    input  logic [sccb_pkg::DATA_W-1:0]  i_data,
    input  logic                         i_sda_in,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic                         i_scl,
    input  logic                         i_sda_out,
    input  logic                         i_sda_drive,
    input  logic                         i_busy_res,
    input  logic                         i_done_res,
    input  logic                         i_ack_ok,
    input  logic [sccb_pkg::BYTE_W-1:0]  i_read_data,
    input  logic                         i_rejected,
    input  logic                         i_cfg_we,
    input  logic [sccb_pkg::TICK_W-1:0]  i_cfg_wdata,
    output int                           o_errors,
    output int                           o_pending,
    output int                           o_checked,
    output int                           o_finished,
    output int                           o_rejected
);
    import sccb_pkg::*;

    localparam logic [TICK_W-1:0] TICKS_AFTER_RESET = 16'd100;

    // shadow copy of the engine
    t_cmd              run_cmd;
    logic [4:0]        step;
    logic [3:0]        bit_idx;
    logic [DATA_W-1:0] shreg;
    logic [TICK_W-1:0] tick_cnt;
    logic [TICK_W-1:0] ticks_per_phase;
    logic              scl_q;
    logic              sda_q;
    logic              drv_q;
    logic              word_hi_done;
    logic              ack_seen;

    // bus states still owed by the block, oldest first
    t_result bus_state_q[$];

    // one line per mismatch
    task automatic report_mismatch(input string what, input int got, input int want);
        o_errors++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d (beat %0d)",
                 $time, what, got, want, o_checked);
    endtask

    // line changes made on entry to the current phase
    function automatic void enter_phase(input logic sda);
        case (run_cmd)
            CMD_START: begin
                case (step)
                    5'd0: begin
                        drv_q = 1'b1;
                        sda_q = 1'b1;
                    end
                    5'd1: scl_q = 1'b1;
                    5'd2: sda_q = 1'b0;
                    5'd3: scl_q = 1'b0;
                    default: ;
                endcase
            end
            CMD_STOP: begin
                case (step)
                    5'd0: sda_q = 1'b0;
                    5'd1: scl_q = 1'b1;
                    5'd2: sda_q = 1'b1;
                    default: ;
                endcase
            end
            CMD_NOACK: begin
                case (step)
                    5'd0: sda_q = 1'b1;
                    5'd1: scl_q = 1'b1;
                    5'd2: scl_q = 1'b0;
                    5'd3: sda_q = 1'b0;
                    default: ;
                endcase
            end
            CMD_WBYTE, CMD_WWORD: begin
                case (step)
                    5'd0: sda_q = shreg[15 - bit_idx[2:0]];
                    5'd1: scl_q = 1'b1;
                    5'd2: scl_q = 1'b0;
                    5'd4: drv_q = 1'b0;
                    5'd5: scl_q = 1'b1;
                    5'd6: begin
                        ack_seen = !sda;
                        scl_q    = 1'b0;
                    end
                    default: ;
                endcase
            end
            CMD_RBYTE: begin
                case (step)
                    5'd0: drv_q = 1'b0;
                    5'd2: scl_q = 1'b1;
                    5'd3: begin
                        shreg = {8'h00, shreg[6:0], sda};
                        scl_q = 1'b0;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    endfunction

    // step to the next phase, returns 1 once the command is over
    function automatic logic next_phase(input logic sda);
        logic fin;
        fin = 1'b0;
        case (run_cmd)
            CMD_START, CMD_NOACK: begin
                step = step + 5'd1;
                fin  = (step >= 5'd4);
            end
            CMD_STOP: begin
                step = step + 5'd1;
                fin  = (step >= 5'd3);
            end
            CMD_WBYTE, CMD_WWORD: begin
                if (step < 5'd2) begin
                    step = step + 5'd1;
                end else if (step == 5'd2) begin
                    if (bit_idx < 4'd7) begin
                        bit_idx = bit_idx + 4'd1;
                        step    = 5'd0;
                    end else begin
                        step = 5'd3;
                    end
                end else if (step < 5'd6) begin
                    step = step + 5'd1;
                end else begin
                    drv_q = 1'b1;
                    // low byte follows only after an acknowledged high byte
                    if (run_cmd == CMD_WWORD && !word_hi_done && ack_seen) begin
                        word_hi_done = 1'b1;
                        shreg        = {shreg[7:0], 8'h00};
                        step         = 5'd0;
                        bit_idx      = 4'd0;
                    end else begin
                        fin = 1'b1;
                    end
                end
            end
            CMD_RBYTE: begin
                if (step == 5'd0) begin
                    step    = 5'd1;
                    bit_idx = 4'd0;
                end else if (step < 5'd3) begin
                    step = step + 5'd1;
                end else if (bit_idx < 4'd7) begin
                    bit_idx = bit_idx + 4'd1;
                    step    = 5'd1;
                end else begin
                    drv_q = 1'b1;
                    fin   = 1'b1;
                end
            end
            default: fin = 1'b1;
        endcase
        if (!fin)
            enter_phase(sda);
        return fin;
    endfunction

    // advance the shadow engine by one tick and give the bus state it leaves
    function automatic t_result bus_tick(input logic [KIND_W-1:0] kind,
                                         input logic [DATA_W-1:0] data,
                                         input logic sda);
        t_result res;
        logic    is_cmd;
        res    = '0;
        is_cmd = (kind >= CMD_START && kind <= CMD_WWORD);
        if (run_cmd != CMD_IDLE) begin
            res.rejected = is_cmd;
            if (tick_cnt >= ticks_per_phase) begin
                tick_cnt = 16'd1;
                if (next_phase(sda)) begin
                    res.done = 1'b1;
                    if (run_cmd == CMD_WBYTE || run_cmd == CMD_WWORD)
                        res.ack_ok = ack_seen;
                    if (run_cmd == CMD_RBYTE)
                        res.read_data = shreg[7:0];
                    run_cmd  = CMD_IDLE;
                    step     = 5'd0;
                    bit_idx  = 4'd0;
                    tick_cnt = '0;
                end
            end else begin
                tick_cnt = tick_cnt + 16'd1;
            end
        end else if (is_cmd) begin
            // accepted: the first phase starts on this very tick
            run_cmd      = t_cmd'(kind);
            step         = 5'd0;
            bit_idx      = 4'd0;
            word_hi_done = 1'b0;
            ack_seen     = 1'b0;
            tick_cnt     = 16'd1;
            case (run_cmd)
                CMD_WWORD: shreg = data;
                CMD_WBYTE: shreg = {data[7:0], 8'h00};
                default:   shreg = '0;
            endcase
            enter_phase(sda);
        end
        res.scl       = scl_q;
        res.sda_out   = sda_q;
        res.sda_drive = drv_q;
        res.busy      = (run_cmd != CMD_IDLE);
        return res;
    endfunction

    // watch both channels and the register port
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            run_cmd         = CMD_IDLE;
            step            = 5'd0;
            bit_idx         = 4'd0;
            shreg           = '0;
            tick_cnt        = '0;
            ticks_per_phase = TICKS_AFTER_RESET;
            scl_q           = 1'b1;
            sda_q           = 1'b1;
            drv_q           = 1'b1;
            word_hi_done    = 1'b0;
            ack_seen        = 1'b0;
            bus_state_q.delete();
            o_pending = 0;
        end else begin
            if (i_cfg_we)
                ticks_per_phase = i_cfg_wdata;

            // result beat against the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                got.scl       = i_scl;
                got.sda_out   = i_sda_out;
                got.sda_drive = i_sda_drive;
                got.busy      = i_busy_res;
                got.done      = i_done_res;
                got.ack_ok    = i_ack_ok;
                got.read_data = i_read_data;
                got.rejected  = i_rejected;
                if (bus_state_q.size() == 0) begin
                    report_mismatch("result beat with none outstanding", 1, 0);
                end else begin
                    want = bus_state_q.pop_front();
                    if (got.scl !== want.scl)
                        report_mismatch("scl", got.scl, want.scl);
                    if (got.sda_out !== want.sda_out)
                        report_mismatch("sda_out", got.sda_out, want.sda_out);
                    if (got.sda_drive !== want.sda_drive)
                        report_mismatch("sda_drive", got.sda_drive, want.sda_drive);
                    if (got.busy !== want.busy)
                        report_mismatch("busy_res", got.busy, want.busy);
                    if (got.done !== want.done)
                        report_mismatch("done_res", got.done, want.done);
                    if (got.ack_ok !== want.ack_ok)
                        report_mismatch("ack_ok", got.ack_ok, want.ack_ok);
                    if (got.read_data !== want.read_data)
                        report_mismatch("read_data", got.read_data, want.read_data);
                    if (got.rejected !== want.rejected)
                        report_mismatch("rejected", got.rejected, want.rejected);
                end
                o_checked++;
            end

            // input beat drives the shadow engine
            if (i_in_valid && !i_in_stall) begin
                want = bus_tick(i_kind, i_data, i_sda_in);
                if (want.done)
                    o_finished++;
                if (want.rejected)
                    o_rejected++;
                bus_state_q.push_back(want);
            end
            o_pending = bus_state_q.size();
        end
    end

endmodule

/* verif/tb_sccb_master_bit_engine.sv */
`timescale 1ns / 1ps

module tb_sccb_master_bit_engine;
    import sccb_pkg::*;

    localparam logic [KIND_W-1:0] KIND_TICK    = CMD_IDLE;
    localparam logic [KIND_W-1:0] KIND_SPARE   = 3'd7;
    localparam int                SDA_LOW      = 0;
    localparam int                SDA_HIGH     = 1;
    localparam int                SDA_RANDOM   = 2;
    localparam int                DRAIN_CYCLES = 8;
    localparam int                CYCLE_LIMIT  = 5_000_000;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [KIND_W-1:0] i_kind;
    logic [DATA_W-1:0] i_data;
    logic              i_sda_in;
    logic              o_valid;
    logic              i_stall;
    logic              o_scl;
    logic              o_sda_out;
    logic              o_sda_drive;
    logic              o_busy_res;
    logic              o_done_res;
    logic              o_ack_ok;
    logic [BYTE_W-1:0] o_read_data;
    logic              o_rejected;
    logic              i_cfg_we;
    logic [TICK_W-1:0] i_cfg_wdata;

    int mismatch_cnt;
    int pending;
    int checked;
    int finished;
    int refused;

    int          burst_left = 0;
    int          beats_sent = 0;
    int          cycle_cnt  = 0;
    int          stall_mode = 0;
    int          stall_run  = 0;
    logic [15:0] cur_ticks  = 16'd100;

    always #5 i_clk = ~i_clk;

    sccb_master_bit_engine u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_kind      (i_kind),
        .i_data      (i_data),
        .i_sda_in    (i_sda_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_scl       (o_scl),
        .o_sda_out   (o_sda_out),
        .o_sda_drive (o_sda_drive),
        .o_busy_res  (o_busy_res),
        .o_done_res  (o_done_res),
        .o_ack_ok    (o_ack_ok),
        .o_read_data (o_read_data),
        .o_rejected  (o_rejected),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    sccb_master_bit_engine_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_stall  (o_stall),
        .i_kind      (i_kind),
        .i_data      (i_data),
        .i_sda_in    (i_sda_in),
        .i_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_scl       (o_scl),
        .i_sda_out   (o_sda_out),
        .i_sda_drive (o_sda_drive),
        .i_busy_res  (o_busy_res),
        .i_done_res  (o_done_res),
        .i_ack_ok    (o_ack_ok),
        .i_read_data (o_read_data),
        .i_rejected  (o_rejected),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_errors    (mismatch_cnt),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_finished  (finished),
        .o_rejected  (refused)
    );

    // run guard
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver back-pressure: quiet, light, heavy and periodic stretches
    always @(negedge i_clk) begin
        if (stall_run == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_run  = $urandom_range(20, 200);
        end
        stall_run--;
        case (stall_mode)
            0:       i_stall <= 1'b0;
            1:       i_stall <= ($urandom_range(0, 7) == 0);
            2:       i_stall <= ($urandom_range(0, 1) == 0);
            default: i_stall <= ((stall_run % 16) < 11);
        endcase
    end

    // one input beat, sent in bursts with random gaps between them
    task automatic push_beat(input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] data,
                             input logic sda);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        @(negedge i_clk);
        i_valid  <= 1'b1;
        i_kind   <= kind;
        i_data   <= data;
        i_sda_in <= sda;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        burst_left--;
        beats_sent++;
    endtask

    function automatic logic pick_sda(input int mode);
        case (mode)
            SDA_LOW:  return 1'b0;
            SDA_HIGH: return 1'b1;
            default:  return 1'($urandom_range(0, 1));
        endcase
    endfunction

    // waveform phases in a full command
    function automatic int phase_count(input t_cmd cmd);
        case (cmd)
            CMD_START, CMD_NOACK: return 4;
            CMD_STOP:             return 3;
            CMD_WBYTE:            return 28;
            CMD_RBYTE:            return 25;
            CMD_WWORD:            return 56;
            default:              return 0;
        endcase
    endfunction

    // a command followed by ticks up to its last phase, then extra idle ticks;
    // noise commands land only where the engine is certain to be busy
    task automatic run_command(input t_cmd cmd, input logic [DATA_W-1:0] data,
                               input int sda_mode, input int noise_pct, input int extra);
        int                phase_len;
        int                span;
        int                busy_span;
        logic [KIND_W-1:0] kind;
        phase_len = (cur_ticks == 16'd0) ? 1 : int'(cur_ticks);
        span      = phase_count(cmd) * phase_len;
        // a word may end after its high byte
        busy_span = (cmd == CMD_WWORD) ? phase_count(CMD_WBYTE) * phase_len : span;
        push_beat(cmd, data, pick_sda(sda_mode));
        for (int n = 0; n < span + extra; n++) begin
            kind = KIND_TICK;
            if (n < busy_span && noise_pct > 0) begin
                // a command on the finishing tick, or at random while busy
                if ((n == busy_span - 1 && $urandom_range(0, 3) == 0) ||
                    $urandom_range(0, 99) < noise_pct)
                    kind = ($urandom_range(0, 3) == 0) ? KIND_SPARE
                                                       : 3'($urandom_range(1, 6));
            end
            push_beat(kind, 16'($urandom), pick_sda(sda_mode));
        end
    endtask

    // mostly whole commands with random content, some idle noise
    task automatic random_traffic(input int beats);
        int   stop_at;
        int   mode;
        t_cmd cmd;
        stop_at = beats_sent + beats;
        while (beats_sent < stop_at) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 5))
                    push_beat(($urandom_range(0, 1) == 0) ? KIND_SPARE : KIND_TICK,
                              16'($urandom), 1'($urandom_range(0, 1)));
            end else begin
                cmd  = t_cmd'($urandom_range(1, 6));
                mode = $urandom_range(0, 3);
                if (mode > SDA_RANDOM)
                    mode = SDA_RANDOM;
                run_command(cmd, 16'($urandom), mode, 5, $urandom_range(0, 2));
            end
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        burst_left = 0;
    endtask

    // register write once every owed result has come back
    task automatic set_phase_ticks(input logic [TICK_W-1:0] ticks);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= ticks;
        @(negedge i_clk);
        i_cfg_we  <= 1'b0;
        cur_ticks  = ticks;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_kind      = KIND_TICK;
        i_data      = '0;
        i_sda_in    = 1'b1;
        i_stall     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // phase length out of reset
        run_command(CMD_STOP, 16'h0000, SDA_RANDOM, 0, 1);

        // directed: every command, line extremes, spare kind and collisions
        set_phase_ticks(16'd1);
        push_beat(KIND_SPARE, 16'hFFFF, 1'b1);
        run_command(CMD_START, 16'hFFFF, SDA_HIGH, 0, 0);
        run_command(CMD_STOP, 16'h0000, SDA_LOW, 0, 0);
        run_command(CMD_NOACK, 16'h5AA5, SDA_RANDOM, 0, 1);
        run_command(CMD_WBYTE, 16'hFFFF, SDA_LOW, 0, 0);
        run_command(CMD_WBYTE, 16'h0000, SDA_HIGH, 0, 0);
        run_command(CMD_RBYTE, 16'h0000, SDA_HIGH, 0, 0);
        run_command(CMD_RBYTE, 16'hFFFF, SDA_LOW, 0, 0);
        run_command(CMD_WWORD, 16'hFFFF, SDA_LOW, 0, 0);
        run_command(CMD_WWORD, 16'h0000, SDA_HIGH, 0, 2);
        run_command(CMD_WWORD, 16'hA55A, SDA_RANDOM, 30, 0);
        run_command(CMD_RBYTE, 16'h1234, SDA_RANDOM, 30, 1);

        // random traffic over several phase lengths, zero included
        random_traffic(200);
        set_phase_ticks(16'd2);
        random_traffic(150);
        set_phase_ticks(16'd0);
        random_traffic(100);
        set_phase_ticks(16'd3);
        random_traffic(80);
        set_phase_ticks(16'($urandom_range(4, 7)));
        random_traffic(80);

        // longest phase: a command that stays in its first phase, with collisions
        set_phase_ticks(16'hFFFF);
        push_beat(CMD_STOP, 16'($urandom), 1'($urandom_range(0, 1)));
        repeat (40)
            push_beat(($urandom_range(0, 3) == 0) ? 3'($urandom_range(1, 6)) : KIND_TICK,
                      16'($urandom), 1'($urandom_range(0, 1)));

        wait_drained();
        $display("%0d result beats checked over phase lengths 0 to 65535 and the reset value",
                 checked);
        $display("%0d commands completed, %0d refused while the engine was busy",
                 finished, refused);
        if (mismatch_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
